FILE: rtl/ook_tone_generator_top_macros.svh
// ---------------------------------------------------------------------------
// OOK tone generator assertion macros
// Shared concurrent check forms, clocked on clk and held off during rst.
// ---------------------------------------------------------------------------
`ifndef OOK_TONE_GENERATOR_TOP_MACROS_SVH
`define OOK_TONE_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define OOK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OOK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ook_pkg.sv
// ---------------------------------------------------------------------------
// OOK tone generator package
// Shared types, register codes, reset values and the sine polynomial.
// ---------------------------------------------------------------------------
package ook_pkg;

  localparam int PHASE_BITS_DEF     = 32;
  localparam int SINE_ADDR_BITS_DEF = 10;
  localparam int FRAME_BITS_DEF     = 8;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CODE_W     = 8;
  localparam int KIND_W     = 2;
  localparam int SAMPLE_W   = 16;
  localparam int SPB_W      = 16;
  localparam int AMP_W      = 15;
  localparam int SINE_W     = 31;

  localparam logic [31:0]      PHASE_STEP_RST = 32'd697932186;
  localparam logic [SPB_W-1:0] SPB_RST        = 16'd480;
  localparam logic [AMP_W-1:0] AMP_RST        = 15'd32767;
  localparam logic             MSB_FIRST_RST  = 1'b1;

  // Odd-power sine coefficients, Q30
  localparam logic [63:0] C_A1 = 64'd1686629713;
  localparam logic [63:0] C_A3 = 64'd693598669;
  localparam logic [63:0] C_A5 = 64'd85569306;
  localparam logic [63:0] C_A7 = 64'd5026995;
  localparam logic [63:0] C_A9 = 64'd172272;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2
  } ook_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP = 2'd0,
    REG_SPB        = 2'd1,
    REG_AMPLITUDE  = 2'd2,
    REG_MSB_FIRST  = 2'd3
  } ook_reg_e;

  typedef struct packed {
    logic [31:0]      phase_inc;
    logic [SPB_W-1:0] bit_len;
    logic [AMP_W-1:0] amplitude;
    logic             msb_first;
  } ook_cfg_t;

  // Per-sample control that rides along the pipeline
  typedef struct packed {
    logic neg;     // quadrant 2 or 3: negate the magnitude
    logic on;      // code bit keys the carrier on
    logic last;    // final sample of the frame
    logic active;  // generator was running
  } ook_flags_t;

  // Quarter-wave sine in Q30 for fraction num / 2^qbits
  function automatic logic [SINE_W-1:0] ook_sine_q30(input logic [63:0] num,
                                                      input int qbits);
    logic [63:0] f;
    logic [63:0] f2;
    logic [63:0] t;
    logic [63:0] s;
    f  = num << (30 - qbits);
    f2 = (f * f) >> 30;
    t  = C_A7 - ((f2 * C_A9) >> 30);
    t  = C_A5 - ((f2 * t) >> 30);
    t  = C_A3 - ((f2 * t) >> 30);
    t  = C_A1 - ((f2 * t) >> 30);
    s  = (f * t) >> 30;
    return s[SINE_W-1:0];
  endfunction

endpackage

FILE: rtl/ook_cfg_regs.sv
// ---------------------------------------------------------------------------
// OOK configuration registers
// Write-only register file for carrier step, bit length, level and order.
// ---------------------------------------------------------------------------
module ook_cfg_regs import ook_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output ook_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_inc <= PHASE_STEP_RST;
      cfg.bit_len   <= SPB_RST;
      cfg.amplitude <= AMP_RST;
      cfg.msb_first <= MSB_FIRST_RST;
    end else if (cfg_we) begin
      unique case (ook_reg_e'(cfg_index))
        REG_PHASE_STEP: cfg.phase_inc <= cfg_data[31:0];
        REG_SPB:        cfg.bit_len   <= cfg_data[SPB_W-1:0];
        REG_AMPLITUDE:  cfg.amplitude <= cfg_data[AMP_W-1:0];
        REG_MSB_FIRST:  cfg.msb_first <= cfg_data[0];
      endcase
    end
  end

endmodule

FILE: rtl/ook_seq.sv
// ---------------------------------------------------------------------------
// OOK frame sequencer
// Command decode, bit/tick counters and phase accumulator; emits the
// sine table index and sample flags for every tick.
// ---------------------------------------------------------------------------
module ook_seq import ook_pkg::*; #(
  parameter int PHASE_BITS     = PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
  parameter int FRAME_BITS     = FRAME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ook_cfg_t                 cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic [CODE_W-1:0]        in_code,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [SINE_ADDR_BITS-2:0] out_num,
  output ook_flags_t               out_flags
);

  localparam int QB   = SINE_ADDR_BITS - 2;
  localparam int IDXW = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam logic [IDXW-1:0] IDX_LAST = IDXW'(FRAME_BITS - 1);
  localparam logic [QB:0]     Q_FULL   = (QB+1)'(1) << QB;

  logic                  running;
  logic [CODE_W-1:0]     held_code;
  logic [IDXW-1:0]       bit_index;
  logic [SPB_W-1:0]      tick_count;
  logic [PHASE_BITS-1:0] phase_acc;

  logic                      accept;
  logic [SPB_W-1:0]          spb;
  logic                      bit_end;
  logic                      frame_end;
  logic [IDXW-1:0]           pos;
  logic [31:0]               pos_ext;
  logic                      key_on;
  logic [SINE_ADDR_BITS-1:0] idx;
  logic [QB:0]               num;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    spb       = (cfg.bit_len == '0) ? SPB_W'(1) : cfg.bit_len;
    bit_end   = ({1'b0, tick_count} + (SPB_W+1)'(1)) >= {1'b0, spb};
    frame_end = (bit_index == IDX_LAST);
    pos       = cfg.msb_first ? (IDX_LAST - bit_index) : bit_index;
    pos_ext   = 32'(pos);
    key_on    = (pos_ext < 32'd8) && held_code[pos_ext[2:0]];
    idx       = phase_acc[PHASE_BITS-1 -: SINE_ADDR_BITS];
    num       = idx[QB] ? (Q_FULL - {1'b0, idx[QB-1:0]}) : {1'b0, idx[QB-1:0]};
  end

  // Generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      held_code  <= '0;
      bit_index  <= '0;
      tick_count <= '0;
      phase_acc  <= '0;
    end else if (accept) begin
      unique case (in_kind)
        KIND_START: begin
          held_code  <= in_code;
          running    <= 1'b1;
          bit_index  <= '0;
          tick_count <= '0;
          phase_acc  <= '0;
        end
        KIND_STOP: begin
          running    <= 1'b0;
          bit_index  <= '0;
          tick_count <= '0;
          phase_acc  <= '0;
        end
        KIND_TICK: begin
          if (running) begin
            if (bit_end && frame_end) begin
              phase_acc <= '0;
            end else begin
              phase_acc <= phase_acc + PHASE_BITS'(cfg.phase_inc);
            end
            if (bit_end) begin
              tick_count <= '0;
              bit_index  <= frame_end ? '0 : bit_index + IDXW'(1);
            end else begin
              tick_count <= tick_count + SPB_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output stage: only sample ticks produce a word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && (in_kind == KIND_TICK)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_kind == KIND_TICK)) begin
      out_num          <= num;
      out_flags.neg    <= idx[SINE_ADDR_BITS-1];
      out_flags.on     <= running && key_on;
      out_flags.last   <= running && bit_end && frame_end;
      out_flags.active <= running;
    end
  end

endmodule

FILE: rtl/ook_sine_rom.sv
// ---------------------------------------------------------------------------
// OOK sine table
// Registered quarter-wave Q30 lookup; the full-scale point is kept apart.
// ---------------------------------------------------------------------------
module ook_sine_rom import ook_pkg::*; #(
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [SINE_ADDR_BITS-2:0] in_num,
  input  ook_flags_t                in_flags,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [SINE_W-1:0]         out_sine,
  output ook_flags_t                out_flags
);

  localparam int QB = SINE_ADDR_BITS - 2;
  localparam int QN = 1 << QB;
  localparam logic [SINE_W-1:0] S_FULL = ook_sine_q30(64'(QN), QB);

  logic [SINE_W-1:0] tbl [QN];
  logic              advance;

  for (genvar g = 0; g < QN; g++) begin : g_tbl
    assign tbl[g] = ook_sine_q30(64'(g), QB);
  end

  assign in_ready = !out_valid || out_ready;
  assign advance  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sine  <= in_num[QB] ? S_FULL : tbl[in_num[QB-1:0]];
      out_flags <= in_flags;
    end
  end

endmodule

FILE: rtl/ook_amp.sv
// ---------------------------------------------------------------------------
// OOK amplitude stage
// Scale the sine by the level, round, clamp, apply sign and keying, and
// hold the result word for the output channel.
// ---------------------------------------------------------------------------
module ook_amp import ook_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [AMP_W-1:0]    amplitude,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SINE_W-1:0]   in_sine,
  input  ook_flags_t          in_flags,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_sample,
  output ook_flags_t          out_flags
);

  localparam int PROD_W = AMP_W + SINE_W;

  logic                advance;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   rounded;
  logic [SAMPLE_W-1:0] mag;
  logic [SAMPLE_W-1:0] mag_cap;
  logic [SAMPLE_W-1:0] sample_next;

  assign in_ready = !out_valid || out_ready;
  assign advance  = in_valid && in_ready;

  always_comb begin
    prod    = PROD_W'(amplitude) * PROD_W'(in_sine);
    rounded = prod + (PROD_W'(1) << 29);
    mag     = rounded[30 +: SAMPLE_W];
    mag_cap = (mag > SAMPLE_W'(amplitude)) ? SAMPLE_W'(amplitude) : mag;
    if (!in_flags.on) begin
      sample_next = '0;
    end else if (in_flags.neg) begin
      sample_next = SAMPLE_W'(0) - mag_cap;
    end else begin
      sample_next = mag_cap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sample <= sample_next;
      out_flags  <= in_flags;
    end
  end

endmodule

FILE: rtl/ook_tone_generator_top.sv
// ---------------------------------------------------------------------------
// OOK tone generator top level
// On-off keyed sine carrier: a looping frame of code bits gates an NCO tone.
// ---------------------------------------------------------------------------
// Usage:
//   Input words (s_*): s_tuser holds the kind (tick, start, stop), s_tdata
//   the code byte used by start. Start loads the code and restarts the frame
//   from bit zero with phase zero; stop halts the generator. Neither returns
//   a word. Each tick returns exactly one output word; kind 3 is dropped.
//   Output words (m_*): m_tdata is the signed sample, m_tlast marks the last
//   sample of the frame, m_tuser carries bit_on and active.
//   Pipeline: an accepted tick is registered by the sequencer, then by the sine
//   table, then by the amplitude scaling stage, which drives m_tvalid.
//   Throughput: one word per cycle if m_tready is high; the three stages run
//   at once and each holds its own word, so input is taken while results wait.
//   Stall: when m_tready is low the stages fill, and s_tready drops only once
//   every stage holds a word; nothing is lost or repeated.
//   Reset: rst (synchronous) empties the pipeline, stops the generator and
//   loads the default configuration. Write cfg_* only while idle.
// ---------------------------------------------------------------------------
`include "ook_tone_generator_top_macros.svh"

module ook_tone_generator_top import ook_pkg::*; #(
  parameter int PHASE_BITS     = PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
  parameter int FRAME_BITS     = FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Command / tick stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] code
  input  logic [1:0]            s_tuser,   // [1:0] kind
  // Sample stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // [15:0] sample
  output logic                  m_tlast,   // frame_last
  output logic [1:0]            m_tuser    // [0] bit_on, [1] active
);

  ook_cfg_t                  cfg;
  logic                      seq_valid;
  logic                      seq_ready;
  logic [SINE_ADDR_BITS-2:0] seq_num;
  ook_flags_t                seq_flags;
  logic                      rom_valid;
  logic                      rom_ready;
  logic [SINE_W-1:0]         rom_sine;
  ook_flags_t                rom_flags;
  ook_flags_t                out_flags;
  logic signed [SAMPLE_W:0]  amp_pos;
  logic signed [SAMPLE_W:0]  sample_ext;

  ook_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage 1: decode, counters, phase
  ook_seq #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .FRAME_BITS     (FRAME_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tuser),
    .in_code   (s_tdata),
    .out_valid (seq_valid),
    .out_ready (seq_ready),
    .out_num   (seq_num),
    .out_flags (seq_flags)
  );

  // Stage 2: sine lookup
  ook_sine_rom #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_rom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seq_valid),
    .in_ready  (seq_ready),
    .in_num    (seq_num),
    .in_flags  (seq_flags),
    .out_valid (rom_valid),
    .out_ready (rom_ready),
    .out_sine  (rom_sine),
    .out_flags (rom_flags)
  );

  // Stage 3: level scaling and output register
  ook_amp u_amp (
    .clk        (clk),
    .rst        (rst),
    .amplitude  (cfg.amplitude),
    .in_valid   (rom_valid),
    .in_ready   (rom_ready),
    .in_sine    (rom_sine),
    .in_flags   (rom_flags),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_sample (m_tdata),
    .out_flags  (out_flags)
  );

  assign m_tlast    = out_flags.last;
  assign m_tuser    = {out_flags.active, out_flags.on};

  assign amp_pos    = $signed({2'b00, cfg.amplitude});
  assign sample_ext = $signed({m_tdata[SAMPLE_W-1], m_tdata});

  // An idle tick gives an all-zero word
  `OOK_ASSERT_NOW(a_idle_zero, m_tvalid && !m_tuser[1],
    (m_tdata == '0) && !m_tlast && !m_tuser[0], "idle sample word not zero")

  // A zero bit keys the carrier off
  `OOK_ASSERT_NOW(a_off_silent, m_tvalid && !m_tuser[0],
    m_tdata == '0, "keyed-off sample not zero")

  // Sample never exceeds the programmed level
  `OOK_ASSERT_NOW(a_level_bound, m_tvalid,
    (sample_ext <= amp_pos) && (sample_ext >= -amp_pos), "sample beyond amplitude")

  // An accepted tick always loads the sequencer stage
  `OOK_ASSERT_NEXT(a_fill, s_tvalid && s_tready && (s_tuser == KIND_TICK),
    seq_valid, "tick did not enter the sequencer stage")

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// OOK tone generator testbench
// Drives command and tick words with random gaps and output stalls, predicts
// every sample with a bit-exact model of the keyed NCO and checks each output
// word field by field, across several register settings.
// ---------------------------------------------------------------------------
module testbench;
  import ook_pkg::*;

  // Kind code that the block drops without a result
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
  // Cycles with no word moving on either side before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  // Cycles to let pass after the last expected word, beyond the 3-stage latency
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                bit_on;
    logic                frame_last;
    logic                active;
  } tone_word_t;

  // -------------------------------------------------------------------------
  // Sample scoreboard: shadow registers, generator state and the queue of
  // samples still owed by the block.
  // -------------------------------------------------------------------------
  class tone_scoreboard;
    logic [31:0]      step_size;
    logic [SPB_W-1:0] bit_ticks;
    logic [AMP_W-1:0] level;
    logic             msb_first;

    logic             running;
    logic [7:0]       held_code;
    int               bit_pos;
    int               tick_cnt;
    logic [31:0]      phase;

    tone_word_t       owed_q[$];
    int               mismatches;

    function new();
      step_size  = PHASE_STEP_RST;
      bit_ticks  = SPB_RST;
      level      = AMP_RST;
      msb_first  = MSB_FIRST_RST;
      running    = 1'b0;
      held_code  = '0;
      bit_pos    = 0;
      tick_cnt   = 0;
      phase      = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void set_reg(ook_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PHASE_STEP: step_size = val;
        REG_SPB:        bit_ticks = val[SPB_W-1:0];
        REG_AMPLITUDE:  level     = val[AMP_W-1:0];
        REG_MSB_FIRST:  msb_first = val[0];
        default: ;
      endcase
    endfunction

    // Quarter-wave polynomial sine scaled by the level, signed by quadrant
    function logic [SAMPLE_W-1:0] carrier_level(logic [31:0] ph);
      logic [9:0]  idx;
      logic [63:0] num;
      logic [63:0] f;
      logic [63:0] f2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] mag;
      logic [63:0] neg;
      idx = ph[31:22];
      num = idx[8] ? (64'd256 - {56'd0, idx[7:0]}) : {56'd0, idx[7:0]};
      f   = num << 22;
      f2  = (f * f) >> 30;
      t   = C_A7 - ((f2 * C_A9) >> 30);
      t   = C_A5 - ((f2 * t) >> 30);
      t   = C_A3 - ((f2 * t) >> 30);
      t   = C_A1 - ((f2 * t) >> 30);
      s   = (f * t) >> 30;
      mag = ({49'd0, level} * s + 64'h2000_0000) >> 30;
      if (mag > {49'd0, level}) mag = {49'd0, level};
      neg = 64'd0 - mag;
      return idx[9] ? neg[SAMPLE_W-1:0] : mag[SAMPLE_W-1:0];
    endfunction

    function void note_input(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code);
      tone_word_t w;
      int         ticks;
      int         pos;
      logic       bit_end;
      case (kind)
        KIND_START: begin
          held_code = code;
          running   = 1'b1;
          bit_pos   = 0;
          tick_cnt  = 0;
          phase     = '0;
        end
        KIND_STOP: begin
          running  = 1'b0;
          bit_pos  = 0;
          tick_cnt = 0;
          phase    = '0;
        end
        KIND_TICK: begin
          w = '0;
          if (running) begin
            ticks        = (bit_ticks == 0) ? 1 : int'(bit_ticks);
            pos          = msb_first ? (FRAME_BITS_DEF - 1 - bit_pos) : bit_pos;
            bit_end      = (tick_cnt + 1 >= ticks);
            w.bit_on     = (pos < 8) ? held_code[pos] : 1'b0;
            w.frame_last = bit_end && (bit_pos + 1 >= FRAME_BITS_DEF);
            w.active     = 1'b1;
            w.sample     = w.bit_on ? carrier_level(phase) : '0;
            phase        = phase + step_size;
            if (bit_end) begin
              tick_cnt = 0;
              bit_pos++;
              if (bit_pos >= FRAME_BITS_DEF) begin
                bit_pos = 0;
                phase   = '0;
              end
            end else begin
              tick_cnt++;
            end
          end
          owed_q.insert(owed_q.size(), w);
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, int want, int got);
      mismatches++;
      if (mismatches <= 10)
        $display("tb: mismatch on %s at %0t: expected %0d, got %0d", what, $time, want, got);
    endfunction

    function void check_sample(logic [SAMPLE_W-1:0] sample, logic bit_on,
                               logic frame_last, logic active);
      tone_word_t want;
      if (owed_q.size() == 0) begin
        flag("unexpected word", 0, $signed(sample));
        return;
      end
      want = owed_q.pop_front();
      if (sample !== want.sample) flag("sample", $signed(want.sample), $signed(sample));
      if (bit_on !== want.bit_on) flag("bit_on", want.bit_on, bit_on);
      if (frame_last !== want.frame_last) flag("frame_last", want.frame_last, frame_last);
      if (active !== want.active) flag("active", want.active, active);
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input starts at a known value.
  // -------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = '0;   // [7:0] code
  logic [1:0]            s_tuser   = '0;   // [1:0] kind
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [15:0]           m_tdata;          // [15:0] sample
  logic                  m_tlast;          // frame_last
  logic [1:0]            m_tuser;          // [0] bit_on, [1] active

  // Percent of cycles the sender idles before a word / the receiver stalls
  int gap_pct   = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  tone_scoreboard sb = new();

  always #5 clk = ~clk;

  ook_tone_generator_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  // Receiver: drop m_tready at random in stall_pct cycles out of a hundred
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Monitor: check the output word first, then note the input word; a tick
  // cannot come out in the cycle it goes in, so the order is safe.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_sample(m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
      if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
    end
  end

  // Watchdog: abandon the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one word and hold it until it is taken. The sender first idles
  // for a geometric number of cycles; with no gap, valid stays high.
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(0, 99) < gap_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= code;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(KIND_TICK, CODE_W'($urandom_range(0, 255)));
  endtask

  // Hold the sender off until every owed sample is back, then let the
  // pipeline settle so that start and stop words have surely landed.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; upper data bits carry noise the block must ignore
  task automatic write_reg(input ook_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic load_config(input logic [31:0] step, input logic [SPB_W-1:0] ticks,
                             input logic [AMP_W-1:0] amp, input logic msb);
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_SPB, {16'($urandom), ticks});
    write_reg(REG_AMPLITUDE, {17'($urandom), amp});
    write_reg(REG_MSB_FIRST, {31'($urandom), msb});
    cfg_we <= 1'b0;
  endtask

  // Random words: mostly ticks so frames run deep, with restarts, stops and
  // the occasional reserved kind mixed in. Reserved words do not count.
  task automatic run_random(input int gap, input int stall, input int n);
    int sent;
    int r;
    gap_pct   = gap;
    stall_pct = stall;
    sent      = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_word(KIND_STOP, CODE_W'($urandom_range(0, 255)));
        sent++;
      end else if (r < 8) begin
        send_word(KIND_START, CODE_W'($urandom_range(0, 255)));
        sent++;
      end else if (r < 10) begin
        send_word(KIND_RESERVED, CODE_W'($urandom_range(0, 255)));
      end else begin
        send_ticks(1);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle tick, dropped kind, and a short keyed run at the
    // reset configuration.
    send_ticks(1);
    send_word(KIND_RESERVED, 8'hFF);
    send_word(KIND_START, 8'h81);
    send_ticks(3);
    send_word(KIND_STOP, 8'h00);
    drain();

    // Quarter turn per tick, one tick per bit: lands on every quadrant edge
    // including full-scale peaks, wraps the frame, restarts while running.
    load_config(32'h4000_0000, 16'd1, 15'h7FFF, 1'b1);
    send_word(KIND_START, 8'hA5);
    send_ticks(9);
    send_word(KIND_START, 8'h5A);
    send_ticks(2);
    send_word(KIND_STOP, 8'hFF);
    send_ticks(1);
    drain();

    // Random phases across settings and idling patterns
    load_config($urandom, 16'd3, 15'h7FFF, 1'b1);
    run_random(0, 0, 400);
    drain();

    // Zero bit length acts as one; full-range step; silent carrier
    load_config(32'hFFFF_FFFF, 16'd0, 15'd0, 1'b0);
    run_random(71, 0, 300);
    drain();

    load_config($urandom, 16'd40, 15'd1, 1'b1);
    run_random(0, 71, 350);
    // Leave the generator deep inside a long bit for the shrink below
    send_word(KIND_START, CODE_W'($urandom_range(0, 255)));
    send_ticks(25);
    drain();

    // Bit length shrunk below the running count: the bit ends on the next tick
    load_config(32'd0, 16'd2, 15'd16384, 1'b0);
    run_random(25, 25, 400);
    drain();

    load_config($urandom, 16'hFFFF, 15'($urandom), 1'b1);
    run_random(0, 0, 150);
    drain();

    load_config(PHASE_STEP_RST, 16'd5, 15'($urandom), 1'($urandom));
    run_random(25, 25, 250);
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
